### sv/dpsm_pkg.sv
// types and constants shared by the sparse paged memory block
// no dependencies; compiled before every module of the block
package dpsm_pkg;

  localparam int ADDR_W = 32;
  localparam int DATA_W = 64;
  localparam int BYTE_W = 8;
  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int NBYTES_W = 4;

  // access size codes
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_DWORD = 2'd2;

  // access function codes
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        size_code;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              table_full;
    logic [4:0]        pages_in_use;
  } rsp_t;

  // classified access, one per queue entry
  typedef struct packed {
    logic                          is_write;
    logic [ADDR_W-1:0]             addr;
    logic [ADDR_W-1:0]             last_addr;
    logic [DATA_W-1:0]             wdata;
    logic [LANES-1:0]              lane_en;
    logic [LANES-1:0]              lane_next;
    logic [LANES-1:0][LANE_W-1:0]  lane_idx;
  } job_t;

endpackage

### sv/dpsm_ram.sv
// generic simple dual port ram with registered read data
// no dependencies
module dpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/dpsm_front.sv
// front end: accepts access words, classifies bytes onto lanes and pages,
// and queues them for the back end; uses dpsm_pkg
module dpsm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dpsm_pkg::req_t in_req_i,
  input  logic          clearing_i,
  output logic          job_valid_o,
  input  logic          job_pop_i,
  output dpsm_pkg::job_t job_o
);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [Q_CNT_W-1:0] Q_FULL = Q_CNT_W'(Q_DEPTH);

  dpsm_pkg::job_t job_new;
  dpsm_pkg::job_t mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic [dpsm_pkg::NBYTES_W-1:0] nbytes;
  logic push;

  // byte count, last byte address and lane mapping
  always_comb begin
    logic [dpsm_pkg::LANE_W-1:0] idx;
    unique case (in_req_i.size_code)
      dpsm_pkg::SIZE_BYTE:  nbytes = dpsm_pkg::NBYTES_W'(1);
      dpsm_pkg::SIZE_WORD:  nbytes = dpsm_pkg::NBYTES_W'(4);
      dpsm_pkg::SIZE_DWORD: nbytes = dpsm_pkg::NBYTES_W'(8);
      default:              nbytes = '0;
    endcase
    job_new.is_write  = (in_req_i.func == dpsm_pkg::FUNC_WRITE);
    job_new.addr      = in_req_i.addr;
    job_new.last_addr = in_req_i.addr
                      + dpsm_pkg::ADDR_W'(nbytes) - dpsm_pkg::ADDR_W'(1);
    job_new.wdata     = in_req_i.write_data;
    for (int l = 0; l < dpsm_pkg::LANES; l++) begin
      idx = dpsm_pkg::LANE_W'(l) - in_req_i.addr[dpsm_pkg::LANE_W-1:0];
      job_new.lane_idx[l]  = idx;
      job_new.lane_en[l]   = ({1'b0, idx} < nbytes);
      // lanes below the start lane hold bytes of the following 8-byte row
      job_new.lane_next[l] = (dpsm_pkg::LANE_W'(l) < in_req_i.addr[dpsm_pkg::LANE_W-1:0]);
    end
  end

  assign in_stall_o  = clearing_i | (count_q == Q_FULL);
  assign push        = in_valid_i & ~in_stall_o;
  assign job_valid_o = (count_q != '0);
  assign job_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + Q_PTR_W'(1);
    end
    if (job_pop_i) begin
      rd_ptr_d = rd_ptr_q + Q_PTR_W'(1);
    end
    if (push && !job_pop_i) begin
      count_d = count_q + Q_CNT_W'(1);
    end else if (!push && job_pop_i) begin
      count_d = count_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= job_new;
    end
  end

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Q_FULL) else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_i |-> job_valid_o) else $error("pop from empty queue");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    Q_PTR_W'(wr_ptr_q - rd_ptr_q) == count_q[Q_PTR_W-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

### sv/dpsm_back.sv
// back end: clearing pass, tag scan, page allocation, byte lane access
// and output register; uses dpsm_pkg and dpsm_ram
module dpsm_back #(
  parameter int PAGE_BYTES = 4096,
  parameter int PAGE_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  dpsm_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           clearing_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dpsm_pkg::rsp_t out_rsp_o
);

  localparam int PB_W   = $clog2(PAGE_BYTES);
  localparam int TAG_W  = dpsm_pkg::ADDR_W - PB_W;
  localparam int SLOT_W = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(PAGE_SLOTS + 1);
  localparam int OFF_W  = PB_W - dpsm_pkg::LANE_W;
  localparam int ROWS   = PAGE_SLOTS * (PAGE_BYTES / dpsm_pkg::LANES);
  localparam int ROW_W  = $clog2(ROWS);
  localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(PAGE_SLOTS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC0,
    ST_ALLOC1,
    ST_ACCESS,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic [ROW_W-1:0] clr_row_q, clr_row_d;
  logic [CNT_W-1:0] used_q, used_d, idx_q, idx_d;
  logic cmp_valid_q, cmp_valid_d;
  logic [SLOT_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [SLOT_W-1:0] slot0_q, slot0_d, slot1_q, slot1_d;
  logic ok0_q, ok0_d, ok1_q, ok1_d, cross_q, cross_d;
  logic [TAG_W-1:0] pn0_q, pn0_d, pn1_q, pn1_d;
  dpsm_pkg::job_t job_q, job_d;
  logic out_valid_q, out_valid_d;
  dpsm_pkg::rsp_t out_q, out_d;

  logic tag_we, tag_re;
  logic [SLOT_W-1:0] tag_waddr, tag_raddr;
  logic [TAG_W-1:0] tag_wdata, tag_rdata;

  logic [dpsm_pkg::LANES-1:0] lane_ok, ram_we, ram_re;
  logic [ROW_W-1:0] lane_row [dpsm_pkg::LANES];
  logic [ROW_W-1:0] ram_waddr [dpsm_pkg::LANES];
  logic [dpsm_pkg::BYTE_W-1:0] lane_wdata [dpsm_pkg::LANES];
  logic [dpsm_pkg::BYTE_W-1:0] ram_wdata [dpsm_pkg::LANES];
  logic [dpsm_pkg::BYTE_W-1:0] lane_rdata [dpsm_pkg::LANES];
  logic [dpsm_pkg::DATA_W-1:0] rd_word;
  logic [CNT_W+4:0] used_ext;

  dpsm_ram #(.WIDTH(TAG_W), .DEPTH(PAGE_SLOTS)) u_tag_ram (
    .clk_i,
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  for (genvar g = 0; g < dpsm_pkg::LANES; g++) begin : g_lane
    dpsm_ram #(.WIDTH(dpsm_pkg::BYTE_W), .DEPTH(ROWS)) u_byte_ram (
      .clk_i,
      .we_i    (ram_we[g]),
      .waddr_i (ram_waddr[g]),
      .wdata_i (ram_wdata[g]),
      .re_i    (ram_re[g]),
      .raddr_i (lane_row[g]),
      .rdata_o (lane_rdata[g])
    );
  end

  // per lane slot, row and data; bytes of the next row sit on the second
  // page when the access crosses a page boundary
  always_comb begin
    logic hi;
    logic [OFF_W-1:0] off;
    logic [SLOT_W-1:0] sl;
    for (int l = 0; l < dpsm_pkg::LANES; l++) begin
      hi  = job_q.lane_next[l] & cross_q;
      off = job_q.lane_next[l] ? job_q.last_addr[PB_W-1:dpsm_pkg::LANE_W]
                               : job_q.addr[PB_W-1:dpsm_pkg::LANE_W];
      sl  = hi ? slot1_q : slot0_q;
      lane_ok[l]    = job_q.lane_en[l] & (hi ? ok1_q : ok0_q);
      lane_row[l]   = ROW_W'({sl, off});
      lane_wdata[l] = job_q.wdata[{job_q.lane_idx[l], 3'b000} +: dpsm_pkg::BYTE_W];
      ram_we[l]     = (state_q == ST_CLEAR)
                    | ((state_q == ST_ACCESS) & job_q.is_write & lane_ok[l]);
      ram_re[l]     = (state_q == ST_ACCESS) & ~job_q.is_write & lane_ok[l];
      ram_waddr[l]  = (state_q == ST_CLEAR) ? clr_row_q : lane_row[l];
      ram_wdata[l]  = (state_q == ST_CLEAR) ? '0 : lane_wdata[l];
    end
  end

  always_comb begin
    rd_word = '0;
    for (int l = 0; l < dpsm_pkg::LANES; l++) begin
      if (lane_ok[l]) begin
        rd_word[{job_q.lane_idx[l], 3'b000} +: dpsm_pkg::BYTE_W] = lane_rdata[l];
      end
    end
  end

  assign used_ext = {5'b0, used_q};

  always_comb begin
    state_d     = state_q;
    clr_row_d   = clr_row_q;
    used_d      = used_q;
    idx_d       = idx_q;
    cmp_valid_d = cmp_valid_q;
    cmp_idx_d   = cmp_idx_q;
    slot0_d     = slot0_q;
    slot1_d     = slot1_q;
    ok0_d       = ok0_q;
    ok1_d       = ok1_q;
    cross_d     = cross_q;
    pn0_d       = pn0_q;
    pn1_d       = pn1_q;
    job_d       = job_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    tag_we      = 1'b0;
    tag_re      = 1'b0;
    tag_waddr   = used_q[SLOT_W-1:0];
    tag_wdata   = pn0_q;
    tag_raddr   = idx_q[SLOT_W-1:0];
    job_pop_o   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_row_d = clr_row_q + ROW_W'(1);
        if (clr_row_q == ROW_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o   = 1'b1;
          job_d       = job_i;
          pn0_d       = job_i.addr[dpsm_pkg::ADDR_W-1:PB_W];
          pn1_d       = job_i.last_addr[dpsm_pkg::ADDR_W-1:PB_W];
          cross_d     = (job_i.addr[dpsm_pkg::ADDR_W-1:PB_W]
                         != job_i.last_addr[dpsm_pkg::ADDR_W-1:PB_W]);
          ok0_d       = 1'b0;
          ok1_d       = 1'b0;
          idx_d       = '0;
          cmp_valid_d = 1'b0;
          state_d     = (job_i.lane_en == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp_valid_q) begin
          if (tag_rdata == pn0_q) begin
            ok0_d   = 1'b1;
            slot0_d = cmp_idx_q;
          end
          if (cross_q && tag_rdata == pn1_q) begin
            ok1_d   = 1'b1;
            slot1_d = cmp_idx_q;
          end
        end
        if (idx_q != used_q) begin
          tag_re      = 1'b1;
          cmp_valid_d = 1'b1;
          cmp_idx_d   = idx_q[SLOT_W-1:0];
          idx_d       = idx_q + CNT_W'(1);
        end else begin
          cmp_valid_d = 1'b0;
          if (!cmp_valid_q) begin
            state_d = ST_ALLOC0;
          end
        end
      end
      ST_ALLOC0: begin
        if (!ok0_q && used_q != SLOTS_C) begin
          tag_we  = 1'b1;
          slot0_d = used_q[SLOT_W-1:0];
          used_d  = used_q + CNT_W'(1);
          ok0_d   = 1'b1;
        end
        state_d = ST_ALLOC1;
      end
      ST_ALLOC1: begin
        tag_wdata = pn1_q;
        if (cross_q && !ok1_q && used_q != SLOTS_C) begin
          tag_we  = 1'b1;
          slot1_d = used_q[SLOT_W-1:0];
          used_d  = used_q + CNT_W'(1);
          ok1_d   = 1'b1;
        end
        state_d = ST_ACCESS;
      end
      ST_ACCESS: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.read_data    = job_q.is_write ? '0 : rd_word;
          out_d.table_full   = (job_q.lane_en != '0) & (~ok0_q | (cross_q & ~ok1_q));
          out_d.pages_in_use = used_ext[4:0];
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_row_q   <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      slot0_q     <= '0;
      slot1_q     <= '0;
      ok0_q       <= 1'b0;
      ok1_q       <= 1'b0;
      cross_q     <= 1'b0;
      pn0_q       <= '0;
      pn1_q       <= '0;
      job_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_row_q   <= clr_row_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      cmp_valid_q <= cmp_valid_d;
      cmp_idx_q   <= cmp_idx_d;
      slot0_q     <= slot0_d;
      slot1_q     <= slot1_d;
      ok0_q       <= ok0_d;
      ok1_q       <= ok1_d;
      cross_q     <= cross_d;
      pn0_q       <= pn0_d;
      pn1_q       <= pn1_d;
      job_q       <= job_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SLOTS_C) else $error("slot count above table size");

  a_used_alloc_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |->
      (($past(state_q) == ST_ALLOC0 || $past(state_q) == ST_ALLOC1)
       && used_q == $past(used_q) + CNT_W'(1)))
    else $error("slot count changed outside allocation");

  a_read_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCESS && !job_q.is_write) |-> (ram_we == '0))
    else $error("byte store written during a read access");
`endif

endmodule

### sv/demand_paged_sparse_memory.sv
// top level of the demand paged sparse byte memory
// depends on dpsm_pkg, dpsm_front, dpsm_back and dpsm_ram
//
// sparse byte memory over a 32-bit address space. each request word reads
// or writes 1, 4 or 8 little-endian bytes at in_req_i.addr; pages are given
// slots of a fully associative tag table on first touch, in byte order,
// so a page-crossing access may take two slots. with no free slot, the
// bytes of that page are dropped on writes, read as zero, and table_full
// is set in the response word.
// channels: request in (in_valid_i, in_stall_o, in_req_i) and response out
// (out_valid_o, out_stall_i, out_rsp_o), one response word per request.
// after reset a clearing pass zeroes the byte store, one 8-byte row per
// cycle, with in_stall_o high throughout. a request passes the front queue,
// then the back end states scan, alloc0, alloc1, access and result, and its
// response word is registered; the tag search reads the tag ram one slot
// per cycle over the pages in use before the access, and the unused size
// code skips search and allocation. the back end takes one item at a time,
// popping the next only after the last response is in the output register.
// the response sits in an output register and holds while out_stall_i is
// high; the back end waits only when that register is still full.
module demand_paged_sparse_memory #(
  parameter int PAGE_BYTES = 4096,
  parameter int PAGE_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dpsm_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dpsm_pkg::rsp_t out_rsp_o
);

  // queue between the classifying front and the executing back
  logic           job_valid;
  logic           job_pop;
  dpsm_pkg::job_t job;
  // high while the byte store is being zeroed
  logic           clearing;

  // front: size decode, lane mapping, last byte address, queue
  dpsm_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_req_i,
    .clearing_i  (clearing),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop),
    .job_o       (job)
  );

  // back: tag search, allocation, eight byte lanes, response register
  dpsm_back #(
    .PAGE_BYTES (PAGE_BYTES),
    .PAGE_SLOTS (PAGE_SLOTS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .clearing_o  (clearing),
    .out_valid_o,
    .out_stall_i,
    .out_rsp_o
  );

endmodule

### tb/dpsm_checker.sv
// response checker for the demand paged sparse memory: keeps its own page table
// and byte store, predicts every response word and compares it on arrival
// depends on dpsm_pkg; instantiated beside the block by the test top
`timescale 1ns / 100ps

module dpsm_checker #(
  parameter int PAGE_BYTES = 4096,
  parameter int PAGE_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  dpsm_pkg::req_t in_req_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  dpsm_pkg::rsp_t out_rsp_i,
  output int             fail_count_o,
  output int             outstanding_o,
  output int             checked_o,
  output int             full_seen_o
);

  localparam int MAX_REPORTS = 10;

  logic [dpsm_pkg::ADDR_W-1:0] page_tags [PAGE_SLOTS];
  logic [dpsm_pkg::BYTE_W-1:0] byte_store [PAGE_SLOTS*PAGE_BYTES];
  int                pages_used;

  dpsm_pkg::rsp_t rsp_expected_q [$];
  dpsm_pkg::rsp_t rsp_expected;
  int   fail_count;
  int   reported;
  int   checked;
  int   full_seen;

  // one access, bytes in ascending order, allocating pages on first touch
  function automatic dpsm_pkg::rsp_t predict_access(input dpsm_pkg::req_t acc);
    int unsigned                 nbytes;
    int unsigned                 slot;
    int unsigned                 pos;
    logic [dpsm_pkg::ADDR_W-1:0] a;
    logic [dpsm_pkg::ADDR_W-1:0] pn;
    bit                          found;
    dpsm_pkg::rsp_t              rsp;
    case (acc.size_code)
      dpsm_pkg::SIZE_BYTE:  nbytes = 1;
      dpsm_pkg::SIZE_WORD:  nbytes = 4;
      dpsm_pkg::SIZE_DWORD: nbytes = 8;
      default:              nbytes = 0;
    endcase
    rsp  = '0;
    slot = 0;
    for (int i = 0; i < nbytes; i++) begin
      a     = acc.addr + 32'(i);
      pn    = a / PAGE_BYTES;
      found = 1'b0;
      for (int s = 0; s < pages_used; s++) begin
        if (!found && page_tags[s] == pn) begin
          found = 1'b1;
          slot  = s;
        end
      end
      if (!found && pages_used < PAGE_SLOTS) begin
        page_tags[pages_used] = pn;
        slot                  = pages_used;
        pages_used++;
        found = 1'b1;
      end
      if (!found) begin
        rsp.table_full = 1'b1;
      end else begin
        pos = slot * PAGE_BYTES + (a % PAGE_BYTES);
        if (acc.func == dpsm_pkg::FUNC_WRITE) begin
          byte_store[pos] = acc.write_data[i*8 +: 8];
        end else begin
          rsp.read_data[i*8 +: 8] = byte_store[pos];
        end
      end
    end
    rsp.pages_in_use = 5'(pages_used);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_expected_q.delete();
      pages_used = 0;
      for (int k = 0; k < PAGE_SLOTS*PAGE_BYTES; k++) byte_store[k] = '0;
      fail_count    = 0;
      reported      = 0;
      checked       = 0;
      full_seen     = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
      full_seen_o   <= 0;
    end else begin
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        rsp_expected_q.push_back(predict_access(in_req_i));
      end
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (rsp_expected_q.size() == 0) begin
          fail_count++;
          if (reported < MAX_REPORTS) begin
            reported++;
            $display("%t: response word with nothing pending: data %h full %b pages %0d",
                     $realtime, out_rsp_i.read_data, out_rsp_i.table_full,
                     out_rsp_i.pages_in_use);
          end
        end else begin
          rsp_expected = rsp_expected_q.pop_front();
          checked++;
          if (rsp_expected.table_full) full_seen++;
          if (out_rsp_i.read_data !== rsp_expected.read_data ||
              out_rsp_i.table_full !== rsp_expected.table_full ||
              out_rsp_i.pages_in_use !== rsp_expected.pages_in_use) begin
            fail_count++;
            if (reported < MAX_REPORTS) begin
              reported++;
              $display("%t: mismatch exp data %h full %b pages %0d, got data %h full %b pages %0d",
                       $realtime, rsp_expected.read_data, rsp_expected.table_full,
                       rsp_expected.pages_in_use, out_rsp_i.read_data,
                       out_rsp_i.table_full, out_rsp_i.pages_in_use);
            end
          end
        end
      end
      fail_count_o  <= fail_count;
      outstanding_o <= rsp_expected_q.size();
      checked_o     <= checked;
      full_seen_o   <= full_seen;
    end
  end

endmodule

### tb/demand_paged_sparse_memory_test.sv
// test top for the demand paged sparse memory: clock, reset, request words
// and response stall, with the checker watching both channels
// depends on dpsm_pkg, dpsm_checker and the block itself
`timescale 1ns / 100ps

module demand_paged_sparse_memory_test;

  // default geometry of the block: 4 KiB pages, 16 slots
  localparam int PAGE_BITS      = 12;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int QUIET_ITEMS    = 250;    // tail of the run with no idling at all
  localparam int DRAIN_CYCLES   = 40;     // extra wait once no response word is pending
  // the clearing pass after reset holds in_stall_o high, so the limit on
  // cycles without any accepted word sits well above the length of that pass
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int POOL_PAGES     = 24;
  localparam int HOME_PAGES     = 16;     // pages that the directed part allocates
  localparam logic [1:0] SIZE_NONE = 2'd3;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  dpsm_pkg::req_t in_req_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  dpsm_pkg::rsp_t out_rsp_o;

  int fail_count;
  int outstanding;
  int checked;
  int full_seen;

  // page numbers the stimulus draws from: the first HOME_PAGES end up
  // allocated, the rest are left to hit the full table
  logic [19:0] page_pool [POOL_PAGES];

  bit quiet       = 1'b0;
  int stall_left  = 0;
  int idle_cycles = 0;
  int n_reads     = 0;
  int n_writes    = 0;
  int n_unused    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  demand_paged_sparse_memory DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  dpsm_checker response_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_req_i      (in_req_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_rsp_i     (out_rsp_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .full_seen_o   (full_seen)
  );

  // response side: stall bursts between free stretches, both of random length,
  // nothing once the quiet tail begins
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left  <= $urandom_range(0, 40);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 11);
    end
  end

  // watchdog: any accepted word on either channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%t: no word accepted for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic dpsm_pkg::req_t access_word(input logic func,
                                                 input logic [dpsm_pkg::ADDR_W-1:0] addr,
                                                 input logic [1:0] size,
                                                 input logic [dpsm_pkg::DATA_W-1:0] data);
    dpsm_pkg::req_t word;
    word.func       = func;
    word.addr       = addr;
    word.size_code  = size;
    word.write_data = data;
    return word;
  endfunction

  // present one request word and hold it until the block takes it;
  // valid stays high so back to back words need no second assignment
  task automatic send_access(input dpsm_pkg::req_t word);
    in_valid_i <= 1'b1;
    in_req_i   <= word;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (word.size_code == SIZE_NONE) n_unused++;
    else if (word.func == dpsm_pkg::FUNC_WRITE) n_writes++;
    else n_reads++;
  endtask

  initial begin
    logic [19:0]          base_page;
    logic [PAGE_BITS-1:0] offset;
    logic [1:0]           size;
    logic                 func;
    int                   pick;

    page_pool[0] = 20'h00000;
    page_pool[1] = 20'h00001;
    page_pool[2] = 20'hFFFFF;
    page_pool[3] = 20'h80000;
    for (int k = 0; k < 6; k++) begin
      page_pool[4+2*k] = 20'($urandom);
      page_pool[5+2*k] = page_pool[4+2*k] + 20'd1;
    end
    for (int k = HOME_PAGES; k < POOL_PAGES; k++) page_pool[k] = 20'($urandom);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part: a read allocates, all-ones round trip, a word across
    // a page end, a dword that wraps the address space, the unused size code
    send_access(access_word(dpsm_pkg::FUNC_READ,  32'h0000_0000, dpsm_pkg::SIZE_BYTE,  '0));
    send_access(access_word(dpsm_pkg::FUNC_WRITE, 32'h0000_0000, dpsm_pkg::SIZE_DWORD, '1));
    send_access(access_word(dpsm_pkg::FUNC_READ,  32'h0000_0000, dpsm_pkg::SIZE_DWORD, '0));
    send_access(access_word(dpsm_pkg::FUNC_WRITE, 32'h0000_0FFE, dpsm_pkg::SIZE_WORD,
                            64'hA5A5_5A5A));
    send_access(access_word(dpsm_pkg::FUNC_READ,  32'h0000_0FFE, dpsm_pkg::SIZE_WORD,  '0));
    send_access(access_word(dpsm_pkg::FUNC_WRITE, 32'hFFFF_FFFC, dpsm_pkg::SIZE_DWORD,
                            64'h0123_4567_89AB_CDEF));
    send_access(access_word(dpsm_pkg::FUNC_READ,  32'hFFFF_FFFC, dpsm_pkg::SIZE_DWORD, '0));
    send_access(access_word(dpsm_pkg::FUNC_READ,  32'hFFFF_FFFF, dpsm_pkg::SIZE_BYTE,  '0));
    send_access(access_word(dpsm_pkg::FUNC_WRITE, 32'h1234_5678, SIZE_NONE,
                            {$urandom, $urandom}));
    send_access(access_word(dpsm_pkg::FUNC_READ,  32'h1234_5678, SIZE_NONE,  '0));
    send_access(access_word(dpsm_pkg::FUNC_WRITE, 32'h8000_0000, dpsm_pkg::SIZE_BYTE,  '1));
    send_access(access_word(dpsm_pkg::FUNC_READ,  32'h8000_0000, dpsm_pkg::SIZE_DWORD, '0));
    // fill the rest of the table two pages at a time with straddling dwords
    for (int k = 0; k < 6; k++) begin
      send_access(access_word(dpsm_pkg::FUNC_WRITE, {page_pool[4+2*k], 12'hFFC},
                              dpsm_pkg::SIZE_DWORD, {$urandom, $urandom}));
    end
    // table now full: a dword half on a fresh page is partly dropped
    send_access(access_word(dpsm_pkg::FUNC_WRITE, {page_pool[15], 12'hFFC},
                            dpsm_pkg::SIZE_DWORD, {$urandom, $urandom}));
    send_access(access_word(dpsm_pkg::FUNC_READ,  {page_pool[15], 12'hFFC},
                            dpsm_pkg::SIZE_DWORD, '0));
    send_access(access_word(dpsm_pkg::FUNC_READ,  {page_pool[16], 12'h123},
                            dpsm_pkg::SIZE_BYTE,  '0));
    send_access(access_word(dpsm_pkg::FUNC_READ,  {page_pool[4],  12'hFFC},
                            dpsm_pkg::SIZE_DWORD, '0));

    // random part: mostly allocated pages so data comes back, some words on
    // pages the full table refuses, a few anywhere in the address space
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
      if (n == RANDOM_ITEMS / 2) begin
        // hold off until every response word is back
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
      end else if (n < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) base_page = page_pool[$urandom_range(0, HOME_PAGES-1)];
      else if (pick < 92) base_page = page_pool[$urandom_range(HOME_PAGES, POOL_PAGES-1)];
      else base_page = 20'($urandom);
      case ($urandom_range(0, 3))
        0:       offset = 12'($urandom_range(4088, 4095));  // straddle the page end
        1:       offset = 12'($urandom_range(0, 7));
        default: offset = 12'($urandom);
      endcase
      size = ($urandom_range(0, 19) == 0) ? SIZE_NONE : 2'($urandom_range(0, 2));
      func = ($urandom_range(0, 1) == 1) ? dpsm_pkg::FUNC_WRITE : dpsm_pkg::FUNC_READ;
      send_access(access_word(func, {base_page, offset}, size, {$urandom, $urandom}));
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d accesses: %0d reads, %0d writes, %0d with the unused size code",
             n_reads + n_writes + n_unused, n_reads, n_writes, n_unused);
    $display("%0d response words checked, %0d of them with the page table full",
             checked, full_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
